// ===== design/cbp_pkg.sv =====
// Package for the colour bar pattern packer: shared types, constants and the bar colour table.
// Used by cbp_ctrl, cbp_datapath and colour_bar_pattern_packer_top; depends on nothing else.
package cbp_pkg;

  // Largest active width that the bar divider has to handle.
  localparam int CBP_MAX_WIDTH = 4096;

  // Configuration register map, one 32-bit register every four bytes.
  localparam int CBP_ADDR_W = 3;
  localparam logic CBP_REG_ACTIVE_WIDTH = 1'b0;
  localparam logic CBP_REG_PACKING_MODE = 1'b1;

  localparam logic [12:0] CBP_WIDTH_RESET = 13'd1920;

  localparam logic CBP_MODE_UYVY = 1'b0;
  localparam logic CBP_MODE_V210 = 1'b1;

  // White marker geometry and colour.
  localparam logic [7:0]  CBP_MARK_Y       = 8'd235;
  localparam logic [7:0]  CBP_NEUTRAL_C    = 8'd128;
  localparam logic [12:0] CBP_MARK_COLS    = 13'd32;
  localparam logic [11:0] CBP_MARK_LINE_LO = 12'd8;
  localparam logic [11:0] CBP_MARK_LINE_HI = 12'd72;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
  } cbp_colour_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;       // capture an input transaction
    logic       div_step;   // one step of the bar index divider
    logic       emit_uyvy;  // load the output register with a UYVY word
    logic       push;       // push one v210 sample into the pending word
    logic       flush;      // send out the partly filled v210 word
    logic       last;       // the word loaded now ends this pair's results
    logic [1:0] sample_sel; // which of Cb, Y, Cr, Y is pushed
  } cbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a word this cycle
    logic slot_full;  // two samples pending, the next push completes a word
    logic line_end;   // captured line end flag
  } cbp_sts_t;

  // 75% colour bars, left to right.
  function automatic cbp_colour_t cbp_bar_colour(input logic [2:0] bar);
    cbp_colour_t c;
    unique case (bar)
      3'd0:    c = '{y: 8'd180, cb: 8'd128, cr: 8'd128};
      3'd1:    c = '{y: 8'd162, cb: 8'd44,  cr: 8'd142};
      3'd2:    c = '{y: 8'd131, cb: 8'd156, cr: 8'd44};
      3'd3:    c = '{y: 8'd112, cb: 8'd72,  cr: 8'd58};
      3'd4:    c = '{y: 8'd84,  cb: 8'd184, cr: 8'd198};
      3'd5:    c = '{y: 8'd65,  cb: 8'd100, cr: 8'd212};
      3'd6:    c = '{y: 8'd35,  cb: 8'd212, cr: 8'd114};
      default: c = '{y: 8'd16,  cb: 8'd128, cr: 8'd128};
    endcase
    return c;
  endfunction

endpackage

// ===== design/colour_bar_pattern_packer_top.sv =====
// Top level of the colour bar pattern packer: configuration registers and stream ports.
// Depends on cbp_pkg, cbp_ctrl and cbp_datapath.
//
//   Channel  Direction  Handshake            Contents
//   in_      slave      in_tvalid/in_tready  pixel pair position, line end on in_tlast
//   out_     master     out_tvalid/out_tready packed word, last word of the pair on out_tlast
//   cfg_     APB slave  psel/penable/pready  active_width at 0x0, packing_mode at 0x4
//
// A pair is captured, then the restoring bar divider runs, then one word is output in UYVY
// mode or four sample pushes (plus one flush at line end) are made in v210 mode; a word that
// finds the output register occupied waits while out_tready is low.
// The next pair is accepted while the previous word still waits in the output register.
// Synchronous active-low reset clears the packer and restores the register defaults.
module colour_bar_pattern_packer_top
  import cbp_pkg::*;
#(
  parameter int MAX_WIDTH = CBP_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,    // pixel_x [11:0], line_y [23:12], marker_x [35:24]
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,   // packed_word [31:0]
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CBP_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [12:0] active_width_r;
  logic        packing_mode_r;
  logic        cfg_wr;
  cbp_cmd_t    cmd;
  cbp_sts_t    sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r <= CBP_WIDTH_RESET;
      packing_mode_r <= CBP_MODE_UYVY;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        CBP_REG_ACTIVE_WIDTH: active_width_r <= cfg_pwdata[12:0];
        default:              packing_mode_r <= cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      CBP_REG_ACTIVE_WIDTH: cfg_prdata = {19'd0, active_width_r};
      default:              cfg_prdata = {31'd0, packing_mode_r};
    endcase
  end

  cbp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .packing_mode (packing_mode_r),
    .sts          (sts),
    .cmd          (cmd)
  );

  cbp_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .active_width (active_width_r),
    .pixel_x      (in_tdata[11:0]),
    .line_y       (in_tdata[23:12]),
    .marker_x     (in_tdata[35:24]),
    .line_end     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_word     (out_tdata),
    .out_last     (out_tlast)
  );

endmodule

// ===== design/cbp_ctrl.sv =====
// Controller of the colour bar pattern packer: sequences capture, bar division and word output.
// Depends on cbp_pkg; drives cbp_datapath through cbp_cmd_t and reads cbp_sts_t.
module cbp_ctrl
  import cbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     packing_mode,
  input  cbp_sts_t sts,
  output cbp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_EMIT,
    S_PUSH,
    S_FLUSH
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          step_nxt  = 2'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 2'd1;
        if (step_r == 2'd2) begin
          step_nxt  = 2'd0;
          state_nxt = (packing_mode == CBP_MODE_V210) ? S_PUSH : S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_uyvy = 1'b1;
          cmd.last      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_PUSH: begin
        cmd.sample_sel = step_r;
        // A push that completes a word waits for room in the output register.
        if (!sts.slot_full || sts.out_free) begin
          cmd.push = 1'b1;
          // After a completed word, one or two samples remain that line end will flush.
          cmd.last = (step_r == 2'd3) ||
                     (((step_r == 2'd1) || (step_r == 2'd2)) && !sts.line_end);
          step_nxt = step_r + 2'd1;
          if (step_r == 2'd3) begin
            state_nxt = (sts.line_end && !sts.slot_full) ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.emit_uyvy, cmd.push, cmd.flush}))
    else $error("cbp_ctrl: more than one datapath command at once");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_uyvy || cmd.flush || (cmd.push && sts.slot_full)) |-> sts.out_free)
    else $error("cbp_ctrl: word issued while the output register is occupied");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.div_step ##1 cmd.div_step ##1 cmd.div_step)
    else $error("cbp_ctrl: divider did not run three steps after capture");
`endif

endmodule

// ===== design/cbp_datapath.sv =====
// Datapath of the colour bar pattern packer: bar divider, colour lookup, v210 packer, output register.
// Depends on cbp_pkg; commanded by cbp_ctrl.
module cbp_datapath
  import cbp_pkg::*;
#(
  parameter int MAX_WIDTH = CBP_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cbp_cmd_t    cmd,
  output cbp_sts_t    sts,
  input  logic [12:0] active_width,
  input  logic [11:0] pixel_x,
  input  logic [11:0] line_y,
  input  logic [11:0] marker_x,
  input  logic        line_end,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_word,
  output logic        out_last
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW + 1 > 12) ? WW + 1 : 12;

  logic [WW-1:0]   wclip_r;
  logic [CMPW-1:0] rem_r;
  logic [2:0]      quo_r;
  logic            sat_r;
  logic            mark_r;
  logic            le_r;
  logic [29:0]     pending_r;
  logic [1:0]      slot_r;
  logic            out_valid_r;
  logic [31:0]     out_word_r;
  logic            out_last_r;

  logic [13:0]     aw_ext;
  logic [13:0]     max_ext;
  logic [WW-1:0]   wclip_nxt;
  logic [12:0]     mark_end;
  logic            mark_nxt;
  logic [CMPW-1:0] rem_dbl;
  logic [CMPW-1:0] w_ext;
  logic            rem_ge;
  logic [2:0]      bar;
  cbp_colour_t     bar_c;
  cbp_colour_t     pix_c;
  logic [7:0]      sample8;
  logic [9:0]      sample10;
  logic            load_out;
  logic [31:0]     word_nxt;

  // Width clipped to the largest supported line.
  assign aw_ext    = {1'b0, active_width};
  assign max_ext   = 14'(MAX_WIDTH);
  assign wclip_nxt = (aw_ext > max_ext) ? WW'(max_ext) : WW'(aw_ext);

  // The marker's right edge is formed one bit wider so it cannot wrap.
  assign mark_end = {1'b0, marker_x} + CBP_MARK_COLS;
  assign mark_nxt = (pixel_x >= marker_x) && ({1'b0, pixel_x} < mark_end) &&
                    (line_y >= CBP_MARK_LINE_LO) && (line_y < CBP_MARK_LINE_HI);

  // Restoring division for the three quotient bits of pixel_x * 8 / width.
  assign w_ext   = CMPW'(wclip_r);
  assign rem_dbl = {rem_r[CMPW-2:0], 1'b0};
  assign rem_ge  = rem_dbl >= w_ext;

  // A pixel at or past the width (and any pixel at zero width) lands in the last bar.
  assign bar   = sat_r ? 3'd7 : quo_r;
  assign bar_c = cbp_bar_colour(bar);
  assign pix_c = mark_r ? cbp_colour_t'{y: CBP_MARK_Y, cb: CBP_NEUTRAL_C, cr: CBP_NEUTRAL_C}
                        : bar_c;

  always_comb begin
    unique case (cmd.sample_sel)
      2'd0:    sample8 = pix_c.cb;
      2'd2:    sample8 = pix_c.cr;
      default: sample8 = pix_c.y;
    endcase
  end
  assign sample10 = {sample8, 2'b00};

  assign load_out = cmd.emit_uyvy || cmd.flush || (cmd.push && (slot_r == 2'd2));

  always_comb begin
    priority if (cmd.emit_uyvy) begin
      word_nxt = {pix_c.y, pix_c.cr, pix_c.y, pix_c.cb};
    end else if (cmd.flush) begin
      word_nxt = {2'b00, pending_r};
    end else begin
      word_nxt = {2'b00, sample10, pending_r[19:0]};
    end
  end

  // Control and packer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pending_r   <= '0;
      slot_r      <= 2'd0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.flush || (cmd.push && (slot_r == 2'd2))) begin
        pending_r <= '0;
        slot_r    <= 2'd0;
      end else if (cmd.push) begin
        unique case (slot_r)
          2'd0:    pending_r[9:0]   <= sample10;
          default: pending_r[19:10] <= sample10;
        endcase
        slot_r <= slot_r + 2'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wclip_r <= wclip_nxt;
      sat_r   <= CMPW'(pixel_x) >= CMPW'(wclip_nxt);
      rem_r   <= CMPW'(pixel_x);
      quo_r   <= 3'd0;
      mark_r  <= mark_nxt;
      le_r    <= line_end;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? (rem_dbl - w_ext) : rem_dbl;
      quo_r <= {quo_r[1:0], rem_ge};
    end
    if (load_out) begin
      out_word_r <= word_nxt;
      out_last_r <= cmd.last;
    end
  end

  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.slot_full = (slot_r == 2'd2);
  assign sts.line_end  = le_r;

  assign out_tvalid = out_valid_r;
  assign out_word   = out_word_r;
  assign out_last   = out_last_r;

`ifndef ASSERT_OFF
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd3)
    else $error("cbp_datapath: sample slot out of range");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (slot_r == 2'd0) && (pending_r == '0) && out_valid_r)
    else $error("cbp_datapath: flush did not empty the pending word");

  a_full_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && (slot_r == 2'd2)) |=> out_valid_r && (out_word_r[31:30] == 2'b00))
    else $error("cbp_datapath: completed v210 word not presented");
`endif

endmodule

// ===== verif/tb_colour_bar_pattern_packer_top.sv =====
// Self-checking testbench for colour_bar_pattern_packer_top: drives pixel pair transactions,
// predicts the UYVY and v210 words in-line and compares every output transaction in order.
// Depends on cbp_pkg and the design files under design/.
`timescale 1ns / 100ps

module tb_colour_bar_pattern_packer_top;
  import cbp_pkg::*;

  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int PHASE_PAIRS    = 144;
  localparam int MARK_COLS      = 32;
  localparam int LINE_LO        = 8;
  localparam int LINE_HI        = 72;
  localparam logic [7:0] MARK_Y    = 8'd235;
  localparam logic [7:0] NEUTRAL_C = 8'd128;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_kind_t;

  typedef struct packed {
    logic        le;
    logic [11:0] mx;
    logic [11:0] ly;
    logic [11:0] px;
  } pixel_pair_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } packed_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [39:0] in_tdata = '0;    // pixel_x [11:0], line_y [23:12], marker_x [35:24]
  logic        in_tlast = 1'b0;  // line_end
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [31:0] out_tdata;        // packed_word [31:0]
  wire         out_tlast;        // last_word
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CBP_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  wire  [31:0]           cfg_prdata;
  wire                   cfg_pready;

  pixel_pair_t  pending_pairs[$];
  packed_word_t expected_words[$];
  pixel_pair_t  offered_pair;
  logic         in_taken = 1'b0;
  int           pairs_queued = 0;
  logic [11:0]  line_no = '0;

  // Shadow copy of the registers and of the v210 packing state.
  logic [12:0] width_reg = CBP_WIDTH_RESET;
  logic        mode_reg = CBP_MODE_UYVY;
  logic [29:0] v210_acc = '0;
  logic [1:0]  v210_fill = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_asked = 0;
  int holdoff_served = 0;
  int holdoff_left = 0;
  int mismatches = 0;

  colour_bar_pattern_packer_top #(.MAX_WIDTH(CBP_MAX_WIDTH)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // Returns {Y, Cb, Cr} of one 75% bar.
  function automatic logic [23:0] bar_ycbcr(input logic [2:0] bar);
    case (bar)
      3'd0:    return {8'd180, 8'd128, 8'd128};
      3'd1:    return {8'd162, 8'd44,  8'd142};
      3'd2:    return {8'd131, 8'd156, 8'd44};
      3'd3:    return {8'd112, 8'd72,  8'd58};
      3'd4:    return {8'd84,  8'd184, 8'd198};
      3'd5:    return {8'd65,  8'd100, 8'd212};
      3'd6:    return {8'd35,  8'd212, 8'd114};
      default: return {8'd16,  8'd128, 8'd128};
    endcase
  endfunction

  task automatic predict_packed_words(input pixel_pair_t p);
    int           w;
    int           bar;
    int           k;
    logic [7:0]   y;
    logic [7:0]   cb;
    logic [7:0]   cr;
    logic [9:0]   smp [4];
    packed_word_t r;
    packed_word_t words[$];
    w = (int'(width_reg) > CBP_MAX_WIDTH) ? CBP_MAX_WIDTH : int'(width_reg);
    if (w == 0) begin
      bar = 7;
    end else begin
      bar = (int'(p.px) * 8) / w;
      if (bar > 7) bar = 7;
    end
    {y, cb, cr} = bar_ycbcr(bar[2:0]);
    // The marker end is computed in full width, so a marker at the right edge does not wrap.
    if (p.px >= p.mx && int'(p.px) < int'(p.mx) + MARK_COLS &&
        int'(p.ly) >= LINE_LO && int'(p.ly) < LINE_HI) begin
      y  = MARK_Y;
      cb = NEUTRAL_C;
      cr = NEUTRAL_C;
    end
    if (mode_reg == CBP_MODE_UYVY) begin
      r.word = {y, cr, y, cb};
      r.last = 1'b1;
      expected_words.push_back(r);
    end else begin
      smp[0] = {cb, 2'b00};
      smp[1] = {y, 2'b00};
      smp[2] = {cr, 2'b00};
      smp[3] = {y, 2'b00};
      for (k = 0; k < 4; k++) begin
        v210_acc = v210_acc | ({20'd0, smp[k]} << (10 * v210_fill));
        v210_fill = v210_fill + 2'd1;
        if (v210_fill == 2'd3) begin
          r.word = {2'b00, v210_acc};
          r.last = 1'b0;
          words.push_back(r);
          v210_acc = '0;
          v210_fill = '0;
        end
      end
      if (p.le && v210_fill != 2'd0) begin
        r.word = {2'b00, v210_acc};
        r.last = 1'b0;
        words.push_back(r);
        v210_acc = '0;
        v210_fill = '0;
      end
      if (words.size() != 0) begin
        r = words.pop_back();
        r.last = 1'b1;
        words.push_back(r);
      end
      while (words.size() != 0) expected_words.push_back(words.pop_front());
    end
  endtask

  task automatic queue_pair(input int px, input int ly, input int mx, input int le);
    pixel_pair_t p;
    p.px = px[11:0];
    p.ly = ly[11:0];
    p.mx = mx[11:0];
    p.le = le[0];
    pending_pairs.push_back(p);
    pairs_queued++;
  endtask

  // One line of pairs from column 0 to the right edge, thinned out on wide lines,
  // with the marker starting at most 31 columns left of a multiple of the stride.
  task automatic queue_line;
    int span;
    int stride;
    int mx;
    int ly;
    int px;
    span = (int'(width_reg) > CBP_MAX_WIDTH) ? CBP_MAX_WIDTH : int'(width_reg);
    if (span < 64) span = 64;
    stride = (span / 32) & ~1;
    if (stride < 2) stride = 2;
    mx = $urandom_range(0, span / stride) * stride - $urandom_range(0, 31);
    if (mx < 0) mx = 0;
    line_no = (line_no >= 12'd99) ? 12'd0 : line_no + 12'd1;
    ly = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : int'(line_no);
    for (px = 0; px + stride < span; px += stride) queue_pair(px, ly, mx, 0);
    queue_pair(span - 2, ly, mx, 1);
  endtask

  task automatic fill_pairs(input int count);
    int start;
    start = pairs_queued;
    while (pairs_queued - start < count) begin
      if ($urandom_range(0, 99) < 80) begin
        queue_line();
      end else begin
        queue_pair($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 1));
      end
    end
  endtask

  // Waits until every queued pair is taken and every expected word has arrived, then lets
  // the block finish any pair that produces no word.
  task automatic wait_drained;
    @(posedge clk);
    while (pending_pairs.size() != 0 || in_tvalid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == CBP_REG_ACTIVE_WIDTH) begin
      width_reg = val[12:0];
    end else begin
      mode_reg = val[0];
    end
  endtask

  task automatic run_phase(input idle_kind_t kind, input logic mode, input int width,
                           input bit with_holdoff);
    wait_drained();
    write_reg(CBP_REG_ACTIVE_WIDTH, width);
    write_reg(CBP_REG_PACKING_MODE, {31'd0, mode});
    @(posedge clk);
    send_idle_pct  = (kind == IDLE_SEND) ? 86 : (kind == IDLE_BOTH) ? 24 : 0;
    recv_stall_pct = (kind == IDLE_RECV) ? 86 : (kind == IDLE_BOTH) ? 24 : 0;
    if (with_holdoff) begin
      // The receiver stops while a full queue is offered, then the sender waits it out.
      fill_pairs(PHASE_PAIRS / 2);
      holdoff_asked++;
      wait_drained();
      fill_pairs(PHASE_PAIRS / 2);
    end else begin
      fill_pairs(PHASE_PAIRS);
    end
  endtask

  always @(negedge clk) begin : drive_pairs
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        offered_pair = pending_pairs.pop_front();
        in_tdata  <= {4'd0, offered_pair.mx, offered_pair.ly, offered_pair.px};
        in_tlast  <= offered_pair.le;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : track_pairs
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) predict_packed_words(offered_pair);
  end

  always @(negedge clk) begin : count_holdoff
    if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_served != holdoff_asked) begin
      holdoff_left   <= HOLDOFF_CYCLES;
      holdoff_served <= holdoff_served + 1;
    end
  end

  always @(negedge clk) begin : drive_ready
    out_tready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_words
    packed_word_t exp_word;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual word %h last %b",
                 $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        exp_word = expected_words.pop_front();
        if (out_tdata !== exp_word.word) begin
          $display("%0t: packed word mismatch, expected %h, actual %h",
                   $time, exp_word.word, out_tdata);
          mismatches++;
        end
        if (out_tlast !== exp_word.last) begin
          $display("%0t: last word flag mismatch, expected %b, actual %b",
                   $time, exp_word.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset width 1920, UYVY: bar edges, saturation past the width, marker borders,
    // a marker at the far right, an odd column, and a line end that changes nothing.
    queue_pair(0, 0, 0, 0);
    queue_pair(1919, 4095, 4095, 1);
    queue_pair(4095, 8, 4095, 0);
    queue_pair(131, 40, 100, 0);
    queue_pair(132, 71, 100, 0);
    queue_pair(100, 7, 100, 0);
    queue_pair(100, 72, 100, 0);
    queue_pair(100, 71, 100, 0);
    queue_pair(2046, 9, 4080, 1);
    wait_drained();

    // A zero width forces the last bar.
    write_reg(CBP_REG_ACTIVE_WIDTH, 32'd0);
    @(posedge clk);
    queue_pair(500, 20, 0, 0);
    wait_drained();

    // A width past the maximum is clamped.
    write_reg(CBP_REG_ACTIVE_WIDTH, 32'd8191);
    @(posedge clk);
    queue_pair(4095, 0, 0, 0);
    queue_pair(2048, 0, 0, 0);
    queue_pair(2560, 12, 2540, 0);
    wait_drained();

    // v210: walk the pending sample count through every value, with and without a flush.
    write_reg(CBP_REG_ACTIVE_WIDTH, 32'd64);
    write_reg(CBP_REG_PACKING_MODE, {31'd0, CBP_MODE_V210});
    @(posedge clk);
    queue_pair(0, 0, 0, 0);
    queue_pair(8, 0, 0, 0);
    queue_pair(16, 0, 0, 1);
    queue_pair(24, 1, 0, 1);
    queue_pair(32, 2, 0, 0);
    queue_pair(62, 2, 0, 1);
    queue_pair(63, 10, 50, 1);
    queue_pair(4095, 4095, 4095, 1);

    run_phase(IDLE_NONE, CBP_MODE_UYVY, 64, 1'b1);
    run_phase(IDLE_SEND, CBP_MODE_V210, 4096, 1'b0);
    run_phase(IDLE_RECV, CBP_MODE_V210, $urandom_range(64, 4096), 1'b0);
    run_phase(IDLE_BOTH, CBP_MODE_UYVY, 0, 1'b0);
    run_phase(IDLE_NONE, CBP_MODE_V210, 8191, 1'b1);
    run_phase(IDLE_SEND, CBP_MODE_UYVY, $urandom_range(4097, 8191), 1'b0);
    run_phase(IDLE_RECV, CBP_MODE_V210, 1920, 1'b0);
    run_phase(IDLE_BOTH, CBP_MODE_V210, $urandom_range(64, 300), 1'b0);
    wait_drained();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
